### rtl/core/fwpo_pkg.sv
// shared types, constants and quarter-wave table function for the phase oscillator
`default_nettype none

package fwpo_pkg;

    localparam int DEF_PHASE_BITS = 32;
    localparam int DEF_TABLE_BITS = 10;

    localparam int WAVE_W      = 2;
    localparam int FREQ_W      = 32;
    localparam int OFFSET_W    = 32;
    localparam int ELAPSED_W   = 24;
    localparam int SAMPLE_W    = 16;
    localparam int ROM_W       = 15;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam int PROD_W         = FREQ_W + ELAPSED_W;
    localparam int PROD_FRAC_BITS = 40;
    localparam int OFFSET_FRAC_BITS = 32;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [WAVE_W-1:0] WAVE_SINE   = 2'd0;
    localparam logic [WAVE_W-1:0] WAVE_COSINE = 2'd1;
    localparam logic [WAVE_W-1:0] WAVE_SQUARE = 2'd2;
    localparam logic [WAVE_W-1:0] WAVE_SAW    = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] REG_WAVEFORM     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FREQUENCY    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PHASE_OFFSET = 2'd2;

    localparam logic [SAMPLE_W-1:0] Q15_MAX = 16'd32767;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] HALF_Q30    = 64'd536870912;

    typedef struct packed {
        logic [WAVE_W-1:0]   waveform;
        logic [OFFSET_W-1:0] phase_offset;
    } cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // sin(pi/2 * k / 2^tb) in q15, taylor series in q30 with truncated products
    function automatic logic [ROM_W-1:0] quarter_entry(input int k, input int tb);
        logic [63:0] x;
        logic [63:0] theta;
        logic [63:0] theta2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] q15;
        x      = 64'(k) << (30 - tb);
        theta  = (x * HALF_PI_Q30) >> 30;
        theta2 = (theta * theta) >> 30;
        term   = theta;
        sum    = theta;
        term   = ((term * theta2) >> 30) / 64'd6;
        sum    = sum - term;
        term   = ((term * theta2) >> 30) / 64'd20;
        sum    = sum + term;
        term   = ((term * theta2) >> 30) / 64'd42;
        sum    = sum - term;
        term   = ((term * theta2) >> 30) / 64'd72;
        sum    = sum + term;
        term   = ((term * theta2) >> 30) / 64'd110;
        sum    = sum - term;
        term   = ((term * theta2) >> 30) / 64'd156;
        sum    = sum + term;
        q15    = (sum * 64'd32767 + HALF_Q30) >> 30;
        if (q15 > 64'd32767)
        begin
            q15 = 64'd32767;
        end
        return q15[ROM_W-1:0];
    endfunction

endpackage

`default_nettype wire

### rtl/core/fwpo_queue.sv
// short word queue between the front and back parts
`default_nettype none

module fwpo_queue #(
    parameter int WIDTH = fwpo_pkg::DEF_PHASE_BITS
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic [WIDTH-1:0]  push_data,
    input  wire logic              pop,
    output logic [WIDTH-1:0]       pop_data,
    output fwpo_pkg::q_status_t    status
);
    import fwpo_pkg::*;

    localparam int DEPTH = QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data     = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

`default_nettype wire

### rtl/core/fwpo_front.sv
// front part: configuration registers, input word accept and phase increment
`default_nettype none

module fwpo_front #(
    parameter int PHASE_BITS = fwpo_pkg::DEF_PHASE_BITS
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [fwpo_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [fwpo_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [fwpo_pkg::ELAPSED_W-1:0]      elapsed,
    output fwpo_pkg::cfg_t                           cfg,
    input  wire fwpo_pkg::q_status_t                 q_status,
    output logic                                     push,
    output logic [PHASE_BITS-1:0]                    push_data
);
    import fwpo_pkg::*;

    localparam int EXT_W = PROD_W + PHASE_BITS;

    logic [WAVE_W-1:0]   waveform_reg;
    logic [FREQ_W-1:0]   frequency_reg;
    logic [OFFSET_W-1:0] offset_reg;
    logic                front_valid_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [PROD_W-1:0]   prod_next;
    logic [EXT_W-1:0]    prod_ext;
    logic                accept;

    assign cfg_ready = 1'b1;
    assign in_stall  = front_valid_reg && q_status.full;
    assign accept    = in_valid && !in_stall;
    assign prod_next = PROD_W'(frequency_reg) * PROD_W'(elapsed);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waveform_reg  <= '0;
            frequency_reg <= '0;
            offset_reg    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_WAVEFORM:     waveform_reg  <= cfg_data[WAVE_W-1:0];
                REG_FREQUENCY:    frequency_reg <= cfg_data[FREQ_W-1:0];
                REG_PHASE_OFFSET: offset_reg    <= cfg_data[OFFSET_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            front_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prod_reg <= prod_next;
        end
    end

    // product is in units of 2^-40 turn, realign to the accumulator width
    assign prod_ext  = {prod_reg, {PHASE_BITS{1'b0}}};
    assign push      = front_valid_reg && !q_status.full;
    assign push_data = prod_ext[PROD_FRAC_BITS +: PHASE_BITS];

    assign cfg.waveform     = waveform_reg;
    assign cfg.phase_offset = offset_reg;

endmodule

`default_nettype wire

### rtl/core/fwpo_back.sv
// back part: phase accumulator, quarter-wave table and waveform shaping
`default_nettype none

module fwpo_back #(
    parameter int PHASE_BITS = fwpo_pkg::DEF_PHASE_BITS,
    parameter int TABLE_BITS = fwpo_pkg::DEF_TABLE_BITS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire fwpo_pkg::cfg_t                    cfg,
    input  wire fwpo_pkg::q_status_t               q_status,
    output logic                                   pop,
    input  wire logic [PHASE_BITS-1:0]             pop_data,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic signed [fwpo_pkg::SAMPLE_W-1:0]   sample
);
    import fwpo_pkg::*;

    localparam int ROM_DEPTH = (1 << TABLE_BITS) + 1;
    localparam int OFF_W     = OFFSET_W + PHASE_BITS;
    localparam int SAW_W     = PHASE_BITS + 15;
    localparam logic [TABLE_BITS:0] QUARTER = {1'b1, {TABLE_BITS{1'b0}}};
    localparam logic [SAW_W-1:0] SAW_ROUND =
        {{(SAW_W - PHASE_BITS + 1){1'b0}}, 1'b1, {(PHASE_BITS - 2){1'b0}}};

    logic [ROM_W-1:0] rom_table [ROM_DEPTH];

    genvar k;
    generate
        for (k = 0; k < ROM_DEPTH; k++)
        begin : g_rom
            localparam logic [ROM_W-1:0] ENTRY = quarter_entry(k, TABLE_BITS);
            assign rom_table[k] = ENTRY;
        end
    endgenerate

    logic                  advance;
    logic [PHASE_BITS-1:0] acc_reg;
    logic [PHASE_BITS-1:0] acc_next;
    logic [PHASE_BITS-1:0] p_reg;
    logic [PHASE_BITS-1:0] p_next;
    logic [OFF_W-1:0]      off_ext;
    logic                  s1_valid_reg;
    logic                  s2_valid_reg;
    logic                  out_valid_reg;

    logic [1:0]            quad;
    logic [TABLE_BITS-1:0] idx;
    logic [TABLE_BITS:0]   addr;
    logic                  use_rom_next;
    logic [SAMPLE_W-1:0]   alt_next;
    logic [SAW_W-1:0]      saw_sum;
    logic [SAMPLE_W-1:0]   saw_val;
    logic                  p_pos;

    logic [ROM_W-1:0]      rom_q_reg;
    logic                  neg_reg;
    logic                  use_rom_reg;
    logic [SAMPLE_W-1:0]   alt_reg;
    logic [SAMPLE_W-1:0]   rom_ext;
    logic [SAMPLE_W-1:0]   sample_reg;
    logic [SAMPLE_W-1:0]   sample_next;

    assign advance = !out_valid_reg || !out_stall;
    assign pop     = advance && !q_status.empty;

    // stage 1: accumulate and add offset
    assign off_ext  = {cfg.phase_offset, {PHASE_BITS{1'b0}}};
    assign acc_next = acc_reg + pop_data;
    assign p_next   = acc_next + off_ext[OFFSET_FRAC_BITS +: PHASE_BITS];

    // stage 2: table address and non-table waveforms
    assign idx     = p_reg[PHASE_BITS-3 -: TABLE_BITS];
    assign p_pos   = !p_reg[PHASE_BITS-1];
    assign saw_sum = {1'b0, p_reg[PHASE_BITS-2:0], 15'b0}
                   - SAW_W'(p_reg[PHASE_BITS-2:0]) + SAW_ROUND;
    assign saw_val = saw_sum[PHASE_BITS-1 +: SAMPLE_W];

    always_comb
    begin
        quad         = p_reg[PHASE_BITS-1:PHASE_BITS-2];
        use_rom_next = 1'b1;
        alt_next     = '0;
        case (cfg.waveform)
            WAVE_SINE:
            begin
                use_rom_next = 1'b1;
            end
            WAVE_COSINE:
            begin
                quad = p_reg[PHASE_BITS-1:PHASE_BITS-2] + 2'd1;
            end
            WAVE_SQUARE:
            begin
                use_rom_next = 1'b0;
                alt_next     = (p_pos && (p_reg != '0)) ? Q15_MAX : '0;
            end
            WAVE_SAW:
            begin
                use_rom_next = 1'b0;
                alt_next     = p_pos ? Q15_MAX : saw_val;
            end
            default:
            begin
                use_rom_next = 1'b1;
            end
        endcase
        addr = quad[0] ? (QUARTER - {1'b0, idx}) : {1'b0, idx};
    end

    // stage 3: sign and select
    assign rom_ext     = {1'b0, rom_q_reg};
    assign sample_next = use_rom_reg ? (neg_reg ? (~rom_ext + 1'b1) : rom_ext) : alt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                acc_reg <= acc_next;
            end
            if (advance)
            begin
                s1_valid_reg  <= pop;
                s2_valid_reg  <= s1_valid_reg;
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            p_reg       <= p_next;
            rom_q_reg   <= rom_table[addr];
            neg_reg     <= quad[1];
            use_rom_reg <= use_rom_next;
            alt_reg     <= alt_next;
            sample_reg  <= sample_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;

endmodule

`default_nettype wire

### rtl/core/four_wave_phase_oscillator.sv
// four-wave phase oscillator: direct digital synthesizer with sine, cosine, square, saw
//
// usage
//   cfg channel: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0 waveform,
//   1 frequency (2^-16 hz), 2 phase offset (2^-32 turn); ready is always high
//   input channel: in_valid/in_stall with elapsed (2^-24 s) per tick word
//   output channel: out_valid/out_stall with one q1.15 sample word per input word
// path and throughput
//   an accepted word passes the front product, queue, phase, table and sample
//   registers; one word per cycle is taken and delivered while the output is not
//   stalled, set by the phase accumulator loop and the registered table read
// reset
//   rst_n clears the phase accumulator, the configuration registers and all valid flags
// stall
//   a stalled output holds its word and freezes the back pipeline; the two-word
//   queue then fills and in_stall rises while the front holds its word
`default_nettype none

module four_wave_phase_oscillator #(
    parameter int PHASE_BITS = fwpo_pkg::DEF_PHASE_BITS,
    parameter int TABLE_BITS = fwpo_pkg::DEF_TABLE_BITS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [fwpo_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [fwpo_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [fwpo_pkg::ELAPSED_W-1:0]    elapsed,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic signed [fwpo_pkg::SAMPLE_W-1:0]   sample
);
    import fwpo_pkg::*;

    cfg_t                  cfg;
    q_status_t             q_status;
    logic                  push;
    logic [PHASE_BITS-1:0] push_data;
    logic                  pop;
    logic [PHASE_BITS-1:0] pop_data;

    fwpo_front #(
        .PHASE_BITS (PHASE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .elapsed   (elapsed),
        .cfg       (cfg),
        .q_status  (q_status),
        .push      (push),
        .push_data (push_data)
    );

    fwpo_queue #(
        .WIDTH (PHASE_BITS)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    fwpo_back #(
        .PHASE_BITS (PHASE_BITS),
        .TABLE_BITS (TABLE_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_status  (q_status),
        .pop       (pop),
        .pop_data  (pop_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sample    (sample)
    );

endmodule

`default_nettype wire

### rtl/core/fwpo_checker.sv
// port-level checker for the phase oscillator and its bind
`default_nettype none

module fwpo_port_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_stall,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire logic signed [15:0] sample
);

    // output word holds while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sample))
        else $error("output word changed while stalled");

    // samples stay inside plus or minus one
    a_sample_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> sample != -16'sd32768)
        else $error("sample outside q1.15 range");

    // reset leaves no output word pending and the input not stalled
    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !out_valid && !in_stall)
        else $error("pending word during reset");

    // input only backs up when the output side has been stalled
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(out_valid && out_stall))
        else $error("input stalled without output back-pressure");

endmodule

bind four_wave_phase_oscillator fwpo_port_checker u_fwpo_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sample    (sample)
);

`default_nettype wire

### verif/fwpo_checker.sv
// sample checker for the phase oscillator: watches all channels, predicts and compares samples
`timescale 1ns / 100ps

module fwpo_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    input  wire logic                              cfg_ready,
    input  wire logic [fwpo_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [fwpo_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                              in_valid,
    input  wire logic                              in_stall,
    input  wire logic [fwpo_pkg::ELAPSED_W-1:0]    elapsed,
    input  wire logic                              out_valid,
    input  wire logic                              out_stall,
    input  wire logic signed [fwpo_pkg::SAMPLE_W-1:0] sample,
    output int                                     pending,
    output int                                     fail_count
);

    import fwpo_pkg::*;

    localparam int PB      = DEF_PHASE_BITS;
    localparam int TB      = DEF_TABLE_BITS;
    localparam int QUARTER = 1 << TB;
    localparam int ONE_Q15 = 32767;

    localparam logic [PB-1:0] HALF_TURN    = {1'b1, {(PB-1){1'b0}}};
    localparam logic [PB-1:0] QUARTER_TURN = {2'b01, {(PB-2){1'b0}}};

    int sin_table [0:QUARTER];

    logic [WAVE_W-1:0]   wave_sel;
    logic [FREQ_W-1:0]   freq_reg;
    logic [OFFSET_W-1:0] offset_reg;
    logic [PB-1:0]       phase_acc;

    logic signed [SAMPLE_W-1:0] expected_samples [$];
    logic signed [SAMPLE_W-1:0] want;

    int ticks_seen;
    int samples_seen;
    int mismatches = 0;

    assign pending    = ticks_seen - samples_seen;
    assign fail_count = mismatches;

    function automatic int quarter_sin(input int k);
        logic [63:0] x;
        logic [63:0] theta;
        logic [63:0] theta2;
        logic [63:0] term;
        logic [63:0] series;
        logic [63:0] q15;
        int n;
        x      = 64'(k) << (30 - TB);
        theta  = (x * HALF_PI_Q30) >> 30;
        theta2 = (theta * theta) >> 30;
        term   = theta;
        series = theta;
        for (n = 1; n <= 6; n++)
        begin
            term = ((term * theta2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                series = series - term;
            else
                series = series + term;
        end
        q15 = (series * 64'd32767 + 64'd536870912) >> 30;
        if (q15 > 64'd32767)
            q15 = 64'd32767;
        return int'(q15);
    endfunction

    function automatic int sine_at(input logic [PB-1:0] p);
        logic [1:0]    quad;
        logic [TB-1:0] idx;
        int            v;
        quad = p[PB-1 -: 2];
        idx  = p[PB-3 -: TB];
        v    = quad[0] ? sin_table[QUARTER - int'(idx)] : sin_table[idx];
        return quad[1] ? -v : v;
    endfunction

    // advances the phase by one tick and gives the sample for the new phase
    function automatic logic signed [SAMPLE_W-1:0] predict_sample(
        input logic [ELAPSED_W-1:0] e
    );
        logic [PROD_W-1:0] prod;
        logic [PB-1:0]     p;
        int                v;
        prod      = {{ELAPSED_W{1'b0}}, freq_reg} * {{FREQ_W{1'b0}}, e};
        phase_acc = phase_acc + prod[PROD_FRAC_BITS-PB +: PB];
        p         = phase_acc + offset_reg;
        case (wave_sel)
            WAVE_SINE:   v = sine_at(p);
            WAVE_COSINE: v = sine_at(p + QUARTER_TURN);
            WAVE_SQUARE: v = (p != '0 && p < HALF_TURN) ? ONE_Q15 : 0;
            default:
            begin
                if (p < HALF_TURN)
                    v = ONE_Q15;
                else
                    v = int'(((64'(p - HALF_TURN) * 64'd32767) + 64'(QUARTER_TURN)) >> (PB - 1));
            end
        endcase
        if (v > ONE_Q15)
            v = ONE_Q15;
        else if (v < -ONE_Q15)
            v = -ONE_Q15;
        return v[SAMPLE_W-1:0];
    endfunction

    initial
    begin
        for (int k = 0; k <= QUARTER; k++)
        begin
            sin_table[k] = quarter_sin(k);
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_sel     = WAVE_SINE;
            freq_reg     = '0;
            offset_reg   = '0;
            phase_acc    = '0;
            expected_samples.delete();
            ticks_seen   <= 0;
            samples_seen <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_WAVEFORM:     wave_sel   = cfg_data[WAVE_W-1:0];
                    REG_FREQUENCY:    freq_reg   = cfg_data[FREQ_W-1:0];
                    REG_PHASE_OFFSET: offset_reg = cfg_data[OFFSET_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                expected_samples.push_back(predict_sample(elapsed));
                ticks_seen <= ticks_seen + 1;
            end
            if (out_valid && !out_stall)
            begin
                if (expected_samples.size() == 0)
                begin
                    $display("%0t unexpected sample word: expected none, got %0d", $time, sample);
                    mismatches++;
                end
                else
                begin
                    want = expected_samples.pop_front();
                    samples_seen <= samples_seen + 1;
                    if (sample !== want)
                    begin
                        $display("%0t sample mismatch: expected %0d, got %0d", $time, want, sample);
                        mismatches++;
                    end
                end
            end
        end
    end

endmodule

### verif/tb.sv
// testbench top for the phase oscillator: clock, reset, stimulus, stalls and verdict
`timescale 1ns / 100ps

module tb;

    import fwpo_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

    localparam int TICK_GOAL     = 1850;
    localparam int LONG_HOLD     = 300;
    localparam int IDLE_LIMIT    = 5000;
    localparam int SETTLE_CYCLES = 20;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic in_valid;
    logic in_stall;
    logic [ELAPSED_W-1:0] elapsed;
    logic out_valid;
    logic out_stall;
    logic signed [SAMPLE_W-1:0] sample;

    int pending;
    int fail_count;

    bit hold_req = 1'b0;
    bit calm     = 1'b0;
    int ticks      = 0;
    int reg_writes = 0;
    int held_cycles = 0;
    int idle_cycles = 0;

    logic [OFFSET_W-1:0] edge_offsets [0:4];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    four_wave_phase_oscillator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .elapsed   (elapsed),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sample    (sample)
    );

    fwpo_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .elapsed    (elapsed),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample     (sample),
        .pending    (pending),
        .fail_count (fail_count)
    );

    // mostly short, now and then long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 15);
        else
            return $urandom_range(40, 120);
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        reg_writes++;
        @(posedge clk);
    endtask

    task automatic put_tick(input logic [ELAPSED_W-1:0] e);
        in_valid <= 1'b1;
        elapsed  <= e;
        do @(posedge clk); while (in_stall);
        ticks++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    initial
    begin : receiver
        int  n;
        logic s;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                s = 1'b1;
                n = LONG_HOLD;
                hold_req = 1'b0;
                held_cycles += LONG_HOLD;
            end
            else if (calm)
            begin
                s = 1'b0;
                n = 1;
            end
            else if ($urandom_range(0, 2) == 0)
            begin
                s = 1'b1;
                n = gap_len();
            end
            else
            begin
                s = 1'b0;
                n = $urandom_range(1, 10);
            end
            out_stall <= s;
            repeat (n) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t timeout: no word moved for %0d cycles", $time, idle_cycles);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int w;
        int i;
        int r;
        int phase;
        int phase_len;
        logic [FREQ_W-1:0]   freq_pick;
        logic [OFFSET_W-1:0] offs_pick;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        elapsed   = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_WAVEFORM;
        cfg_data  = '0;
        edge_offsets[0] = 32'h0000_0000;
        edge_offsets[1] = 32'h4000_0000;
        edge_offsets[2] = 32'h8000_0000;
        edge_offsets[3] = 32'h7FFF_FFFF;
        edge_offsets[4] = 32'hFFFF_FFFF;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings, zero frequency holds the phase
        put_tick('0);
        put_tick(24'hFF_FFFF);
        wait_drained();

        // quadrant edges, half turn and zero angle on every waveform
        for (w = 0; w < 4; w++)
        begin
            write_reg(REG_WAVEFORM, 32'(w));
            for (i = 0; i < 5; i++)
            begin
                write_reg(REG_PHASE_OFFSET, edge_offsets[i]);
                put_tick(24'($urandom()));
                wait_drained();
            end
        end

        // upper waveform bits dropped, spare index ignored, extreme frequency
        write_reg(REG_WAVEFORM, {30'h3FFF_FFFF, WAVE_SINE});
        write_reg(REG_SPARE, $urandom());
        write_reg(REG_FREQUENCY, 32'hFFFF_FFFF);
        write_reg(REG_PHASE_OFFSET, '0);
        put_tick(24'hFF_FFFF);
        put_tick('0);
        put_tick(24'd1);
        wait_drained();
        write_reg(REG_FREQUENCY, 32'd1);
        put_tick(24'hFF_FFFF);
        wait_drained();

        phase = 0;
        while (ticks < TICK_GOAL)
        begin
            wait_drained();
            calm = (phase % 5 == 3);
            if ($urandom_range(0, 1) == 1)
                write_reg(REG_WAVEFORM, $urandom());
            r = $urandom_range(0, 9);
            if (r == 0)
                freq_pick = '0;
            else if (r == 1)
                freq_pick = '1;
            else if (r < 4)
                freq_pick = $urandom_range(1, 4095);
            else
                freq_pick = $urandom();
            write_reg(REG_FREQUENCY, freq_pick);
            r = $urandom_range(0, 9);
            if (r < 7)
            begin
                offs_pick = (r == 0) ? '0 : (r == 1) ? '1 : $urandom();
                write_reg(REG_PHASE_OFFSET, offs_pick);
            end
            if ($urandom_range(0, 7) == 0)
                write_reg(REG_SPARE, $urandom());
            if (phase == 1 || phase == 7)
                hold_req = 1'b1;
            phase_len = $urandom_range(60, 180);
            for (i = 0; i < phase_len; i++)
            begin
                if (!calm && $urandom_range(0, 3) == 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap_len()) @(posedge clk);
                end
                r = $urandom_range(0, 15);
                if (r == 0)
                    put_tick('0);
                else if (r == 1)
                    put_tick(24'hFF_FFFF);
                else if (r == 2)
                    put_tick(24'($urandom_range(0, 255)));
                else
                    put_tick(24'($urandom()));
            end
            phase++;
        end

        wait_drained();
        calm = 1'b0;
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d ticks in %0d phases with %0d register writes, all waveforms",
                 ticks, phase, reg_writes);
        $display("output held off %0d cycles in long stretches, input drained between phases",
                 held_cycles);
        if (fail_count == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
